[hw/rtl/lir_pkg.sv]
// ----------------------------------------------------------------------------
// lir_pkg: shared types and constants of the linear interpolation resampler
// Holds default widths, the frame limit per source frame and the
// command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package lir_pkg;

    // Default sample and phase fraction widths
    localparam int LIR_SAMPLE_BITS = 24;
    localparam int LIR_FRAC_BITS   = 16;

    // Device frames produced per source frame at most, and counter width
    localparam int LIR_MAX_OUT = 8;
    localparam int LIR_CNT_W   = $clog2(LIR_MAX_OUT);

    // Commands from controller to datapath
    typedef struct packed {
        logic load;    // capture the incoming source frame
        logic mul;     // form difference products for this frame
        logic emit;    // output one interpolated frame and advance the phase
        logic last;    // qualifies emit: final frame of this source frame
        logic pass;    // output the new frame unchanged (unity step)
        logic keep;    // store the first frame, phase untouched
        logic drop;    // no frame due: drop one from the phase
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic step_is_one;
        logic have_prev;
        logic phase_lt_one;
        logic next_lt_one;
        logic slot_free;
    } t_stat;

endpackage

[hw/rtl/lir_if.sv]
// ----------------------------------------------------------------------------
// lir_if: stream channels of the linear interpolation resampler
// Source frames flow in on lir_in_if, device frames flow out on lir_out_if.
// ----------------------------------------------------------------------------
interface lir_in_if #(
    parameter int SAMPLE_BITS = lir_pkg::LIR_SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] in_left;
    logic signed [SAMPLE_BITS-1:0] in_right;

    modport source (output valid, output in_left, output in_right, input ready);
    modport sink   (input valid, input in_left, input in_right, output ready);
endinterface

interface lir_out_if #(
    parameter int SAMPLE_BITS = lir_pkg::LIR_SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] out_left;
    logic signed [SAMPLE_BITS-1:0] out_right;
    logic                          last;

    modport source (output valid, output out_left, output out_right, output last,
                    input ready);
    modport sink   (input valid, input out_left, input out_right, input last,
                    output ready);
endinterface

[hw/rtl/lir_ctrl.sv]
// ----------------------------------------------------------------------------
// lir_ctrl: sequencing controller of the linear interpolation resampler
// Accepts one source frame, decides between passthrough, first-frame store,
// no-output and interpolation, and counts interpolated frames.
// ----------------------------------------------------------------------------
module lir_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  lir_pkg::t_stat i_stat,
    output lir_pkg::t_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECIDE = 2'd1;
    localparam logic [1:0] S_EMIT   = 2'd2;

    localparam logic [lir_pkg::LIR_CNT_W-1:0] CNT_LAST =
        lir_pkg::LIR_CNT_W'(lir_pkg::LIR_MAX_OUT - 1);

    logic [1:0]                     r_state;
    logic [1:0]                     n_state;
    logic [lir_pkg::LIR_CNT_W-1:0]  r_cnt;
    logic [lir_pkg::LIR_CNT_W-1:0]  n_cnt;

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.mul = 1'b1;
                n_cnt     = '0;
                priority if (i_stat.step_is_one) begin
                    if (i_stat.slot_free) begin
                        o_cmd.pass = 1'b1;
                        n_state    = S_IDLE;
                    end
                end else if (!i_stat.have_prev) begin
                    o_cmd.keep = 1'b1;
                    n_state    = S_IDLE;
                end else if (i_stat.phase_lt_one) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.drop = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_EMIT: begin
                if (i_stat.slot_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = !i_stat.next_lt_one || (r_cnt == CNT_LAST);
                    if (o_cmd.last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and frame counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

`ifndef SYNTH
    a_emit_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_stat.slot_free)
        else $error("frame emitted while output register is occupied");

    a_frame_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && r_cnt == CNT_LAST) |-> o_cmd.last)
        else $error("frame limit reached without closing the transaction");

    a_last_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && o_cmd.last) |=> (r_state == S_IDLE))
        else $error("controller did not return to idle after final frame");
`endif

endmodule

[hw/rtl/lir_dp.sv]
// ----------------------------------------------------------------------------
// lir_dp: datapath of the linear interpolation resampler
// Holds the step, phase and previous frame, forms difference products once
// per source frame and steps them by difference*step per device frame.
// ----------------------------------------------------------------------------
module lir_dp #(
    parameter int SAMPLE_BITS = lir_pkg::LIR_SAMPLE_BITS,
    parameter int FRAC_BITS   = lir_pkg::LIR_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lir_pkg::t_cmd                 i_cmd,
    output lir_pkg::t_stat                o_stat,
    input  logic                          i_cfg_we,
    input  logic [FRAC_BITS+2:0]          i_cfg_data,
    input  logic signed [SAMPLE_BITS-1:0] i_in_left,
    input  logic signed [SAMPLE_BITS-1:0] i_in_right,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [SAMPLE_BITS-1:0] o_out_left,
    output logic signed [SAMPLE_BITS-1:0] o_out_right,
    output logic                          o_out_last
);

    localparam int PHASE_BITS = FRAC_BITS + 3;
    localparam int MP_W       = SAMPLE_BITS + FRAC_BITS + 2;
    localparam int PROD_W     = SAMPLE_BITS + PHASE_BITS + 2;

    localparam logic [PHASE_BITS-1:0] ONE       = PHASE_BITS'(1) << FRAC_BITS;
    localparam logic [PHASE_BITS-1:0] PHASE_MAX = '1;

    logic [PHASE_BITS-1:0]         r_step;
    logic [PHASE_BITS-1:0]         r_phase;
    logic                          r_have_prev;
    logic signed [SAMPLE_BITS-1:0] r_prev  [2];
    logic signed [SAMPLE_BITS-1:0] r_new   [2];
    logic signed [PROD_W-1:0]      r_prod  [2];
    logic signed [PROD_W-1:0]      r_dstep [2];
    logic signed [SAMPLE_BITS-1:0] r_out   [2];
    logic                          r_out_last;
    logic                          r_out_valid;

    logic signed [SAMPLE_BITS-1:0] w_in    [2];
    logic signed [SAMPLE_BITS:0]   w_diff  [2];
    logic signed [MP_W-1:0]        w_mp    [2];
    logic signed [PROD_W-1:0]      w_ms    [2];
    logic signed [PROD_W-1:0]      w_sh    [2];
    logic [PHASE_BITS:0]           w_sum;
    logic [PHASE_BITS-1:0]         w_sat;
    logic [PHASE_BITS-1:0]         w_end_phase;
    logic [PHASE_BITS-1:0]         w_drop_phase;
    logic                          w_take_new;

    assign w_in[0] = i_in_left;
    assign w_in[1] = i_in_right;

    // Difference and products for each channel
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            w_diff[k] = {r_new[k][SAMPLE_BITS-1], r_new[k]}
                      - {r_prev[k][SAMPLE_BITS-1], r_prev[k]};
            w_mp[k]   = w_diff[k] * $signed({1'b0, r_phase[FRAC_BITS-1:0]});
            w_ms[k]   = w_diff[k] * $signed({1'b0, r_step});
            w_sh[k]   = r_prod[k] >>> FRAC_BITS;
        end
    end

    // Phase advance with saturation, and the end-of-frame phase drop
    assign w_sum        = {1'b0, r_phase} + {1'b0, r_step};
    assign w_sat        = w_sum[PHASE_BITS] ? PHASE_MAX : w_sum[PHASE_BITS-1:0];
    assign w_end_phase  = (w_sat >= ONE) ? (w_sat - ONE) : '0;
    assign w_drop_phase = (r_phase >= ONE) ? (r_phase - ONE) : '0;
    assign w_take_new   = i_cmd.pass || i_cmd.keep || i_cmd.drop
                        || (i_cmd.emit && i_cmd.last);

    // Step register, phase, previous frame and output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= ONE;
            r_phase     <= '0;
            r_have_prev <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < 2; k++) begin
                r_prev[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_step <= i_cfg_data;
            end
            if (i_cmd.emit) begin
                r_phase <= i_cmd.last ? w_end_phase : w_sat;
            end else if (i_cmd.drop) begin
                r_phase <= w_drop_phase;
            end
            if (i_cmd.pass || i_cmd.keep) begin
                r_have_prev <= 1'b1;
            end
            if (i_cmd.emit || i_cmd.pass) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            for (int k = 0; k < 2; k++) begin
                if (w_take_new) begin
                    r_prev[k] <= r_new[k];
                end
            end
        end
    end

    // Frame capture, product accumulation and output payload
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 2; k++) begin
            if (i_cmd.load) begin
                r_new[k] <= w_in[k];
            end
            if (i_cmd.mul) begin
                r_prod[k]  <= PROD_W'(w_mp[k]);
                r_dstep[k] <= w_ms[k];
            end else if (i_cmd.emit) begin
                r_prod[k] <= r_prod[k] + r_dstep[k];
            end
            if (i_cmd.pass) begin
                r_out[k] <= r_new[k];
            end else if (i_cmd.emit) begin
                r_out[k] <= r_prev[k] + w_sh[k][SAMPLE_BITS-1:0];
            end
        end
        if (i_cmd.pass) begin
            r_out_last <= 1'b1;
        end else if (i_cmd.emit) begin
            r_out_last <= i_cmd.last;
        end
    end

    // Status to controller
    assign o_stat.step_is_one  = (r_step == ONE);
    assign o_stat.have_prev    = r_have_prev;
    assign o_stat.phase_lt_one = (r_phase < ONE);
    assign o_stat.next_lt_one  = (w_sat < ONE);
    assign o_stat.slot_free    = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_left  = r_out[0];
    assign o_out_right = r_out[1];
    assign o_out_last  = r_out_last;

`ifndef SYNTH
    a_emit_fills_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit || i_cmd.pass) |=> r_out_valid)
        else $error("output register not loaded by emitted frame");

    a_phase_below_one_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && !i_cmd.last) |=> (r_phase < ONE))
        else $error("interpolation continued with phase at or above one");

    a_pass_keeps_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.pass || i_cmd.keep) |=> $stable(r_phase))
        else $error("phase changed on passthrough or first frame");
`endif

endmodule

[hw/rtl/linear_interp_resampler.sv]
// ----------------------------------------------------------------------------
// linear_interp_resampler: stereo linear interpolation rate converter
// Converts a stream of source frames to device frames at a 3.16 step ratio.
// ----------------------------------------------------------------------------
// Each accepted source frame yields zero to eight interpolated device frames,
// the final one marked by last; with the step at exactly 1.0 the frame passes
// through unchanged as one marked frame, and otherwise the first frame after
// reset is only stored. A source frame is taken in while idle, then the
// difference products are formed in the multipliers (a passthrough frame
// enters the output register in this step once it is free), then one device
// frame per cycle goes into the single output register while it is free. The
// output register holds a finished frame while the next source frame is taken
// in. The user must write the step register through i_cfg_we/i_cfg_data only
// while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module linear_interp_resampler #(
    parameter int SAMPLE_BITS = lir_pkg::LIR_SAMPLE_BITS,
    parameter int FRAC_BITS   = lir_pkg::LIR_FRAC_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    lir_in_if.sink               i_in,
    lir_out_if.source            o_out,
    input  logic                 i_cfg_we,
    input  logic [FRAC_BITS+2:0] i_cfg_data
);

    lir_pkg::t_cmd  w_cmd;
    lir_pkg::t_stat w_stat;
    logic           w_in_ready;

    // Sequencing
    lir_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    assign i_in.ready = w_in_ready;

    // Arithmetic and state
    lir_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_left   (i_in.in_left),
        .i_in_right  (i_in.in_right),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_out_left  (o_out.out_left),
        .o_out_right (o_out.out_right),
        .o_out_last  (o_out.last)
    );

endmodule
